FILE: hdl/xsh_pkg.sv
// types, codes and line symbols for the xmodem sender handshake
// used by xsh_step and xmodem_sender_handshake_unit; depends on nothing
package xsh_pkg;

  // line symbols
  localparam logic [7:0] SYM_ACK   = 8'h06;
  localparam logic [7:0] SYM_NAK   = 8'h15;
  localparam logic [7:0] SYM_CAN   = 8'h18;
  localparam logic [7:0] SYM_CRC   = 8'h43;
  localparam logic [7:0] SYM_GMODE = 8'h47;

  // request kinds
  localparam logic [2:0] KIND_START   = 3'd0;
  localparam logic [2:0] KIND_BLOCK   = 3'd1;
  localparam logic [2:0] KIND_EOT     = 3'd2;
  localparam logic [2:0] KIND_BYTE    = 3'd3;
  localparam logic [2:0] KIND_TIMEOUT = 3'd4;
  localparam logic [2:0] KIND_ABORT   = 3'd5;

  // allowed_checks codes
  localparam logic [1:0] CHK_SUM_ONLY = 2'd0;
  localparam logic [1:0] CHK_CRC_ONLY = 2'd1;
  localparam logic [1:0] CHK_EITHER   = 2'd2;
  localparam logic [1:0] CHK_NONE     = 2'd3;

  // check methods
  localparam logic [1:0] METH_SUM  = 2'd0;
  localparam logic [1:0] METH_CRC  = 2'd1;
  localparam logic [1:0] METH_NONE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ALLOWED_CHECKS = 2'd0;
  localparam logic [1:0] CFG_ERROR_LIMIT    = 2'd1;

  localparam logic [1:0] ALLOWED_CHECKS_RST = CHK_EITHER;
  localparam logic [7:0] ERROR_LIMIT_RST    = 8'd10;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_BLOCK = 2'd2,
    PH_EOT   = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    ACT_NONE        = 4'd0,
    ACT_START_OK    = 4'd1,
    ACT_BLOCK_ACKED = 4'd2,
    ACT_RESEND_BLK  = 4'd3,
    ACT_RESEND_EOT  = 4'd4,
    ACT_COMPLETE    = 4'd5,
    ACT_NO_ACK      = 4'd6,
    ACT_REMOTE_CAN  = 4'd7,
    ACT_USER_ABORT  = 4'd8,
    ACT_TOO_MANY    = 4'd9,
    ACT_START_TMO   = 4'd10
  } action_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] line_byte;
    logic       new_transfer;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [1:0]  check_method;
    logic [7:0]  phase_errors;
    logic [15:0] total_errors;
  } out_item_t;

  typedef struct packed {
    logic [1:0] allowed_checks;
    logic [7:0] error_limit;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic        can_seen;
    logic [1:0]  method;
    logic [7:0]  try_count;
    logic [15:0] error_total;
  } hs_state_t;

endpackage

FILE: hdl/xsh_step.sv
// next-state and action logic of the sender handshake for one request
// depends on xsh_pkg
module xsh_step (
  input  xsh_pkg::hs_state_t st,
  input  xsh_pkg::cfg_t      cfg,
  input  xsh_pkg::in_item_t  item,
  output xsh_pkg::hs_state_t st_nxt,
  output xsh_pkg::action_t   action
);
  import xsh_pkg::*;

  logic       is_byte;
  logic       is_can;
  logic       is_ack;
  logic [7:0] try_inc;
  logic       lim_hit;
  logic [15:0] total_inc;
  logic       s_ok;
  logic [1:0] s_method;
  logic       can_pair;
  logic       can_first;
  logic       blk_ack;

  // event decode shared by next state and action
  always_comb begin
    is_byte   = (item.kind == KIND_BYTE);
    is_can    = is_byte && (item.line_byte == SYM_CAN);
    is_ack    = is_byte && (item.line_byte == SYM_ACK);
    try_inc   = (st.try_count == 8'hFF) ? st.try_count : st.try_count + 8'd1;
    lim_hit   = (try_inc >= cfg.error_limit);
    total_inc = (st.error_total == 16'hFFFF) ? st.error_total
                                              : st.error_total + 16'd1;
    s_ok      = 1'b0;
    s_method  = st.method;
    if (is_byte && !st.can_seen) begin
      if (item.line_byte == SYM_NAK &&
          (cfg.allowed_checks inside {CHK_SUM_ONLY, CHK_EITHER})) begin
        s_ok     = 1'b1;
        s_method = METH_SUM;
      end else if (item.line_byte == SYM_CRC &&
                   (cfg.allowed_checks inside {CHK_CRC_ONLY, CHK_EITHER})) begin
        s_ok     = 1'b1;
        s_method = METH_CRC;
      end else if (item.line_byte == SYM_GMODE && cfg.allowed_checks == CHK_NONE) begin
        s_ok     = 1'b1;
        s_method = METH_NONE;
      end
    end
    can_pair  = is_can && st.can_seen;
    can_first = is_can && !st.can_seen;
    blk_ack   = is_ack && !st.can_seen;
  end

  // next state
  always_comb begin
    st_nxt = st;
    case (item.kind)
      KIND_START: begin
        st_nxt.phase     = PH_START;
        st_nxt.try_count = 8'd0;
        st_nxt.can_seen  = 1'b0;
        if (item.new_transfer) begin
          st_nxt.error_total = 16'd0;
        end
      end
      KIND_BLOCK: begin
        if (st.phase != PH_BLOCK) begin
          st_nxt.try_count = 8'd0;
        end
        st_nxt.can_seen = 1'b0;
        st_nxt.phase    = (st.method == METH_NONE) ? PH_IDLE : PH_BLOCK;
      end
      KIND_EOT: begin
        if (st.phase != PH_EOT) begin
          st_nxt.try_count = 8'd0;
        end
        st_nxt.can_seen = 1'b0;
        st_nxt.phase    = PH_EOT;
      end
      KIND_BYTE, KIND_TIMEOUT: begin
        case (st.phase)
          PH_START: begin
            st_nxt.can_seen = 1'b0;
            if (s_ok) begin
              st_nxt.method = s_method;
              st_nxt.phase  = PH_IDLE;
            end else if (can_first) begin
              st_nxt.can_seen = 1'b1;
            end else if (can_pair) begin
              st_nxt.phase = PH_IDLE;
            end else begin
              st_nxt.try_count = try_inc;
              if (lim_hit) begin
                st_nxt.phase = PH_IDLE;
              end
            end
          end
          PH_BLOCK: begin
            st_nxt.can_seen = 1'b0;
            if (can_pair || blk_ack) begin
              st_nxt.phase = PH_IDLE;
            end else if (can_first) begin
              st_nxt.can_seen = 1'b1;
            end else begin
              st_nxt.error_total = total_inc;
              st_nxt.try_count   = try_inc;
              if (lim_hit) begin
                st_nxt.phase = PH_IDLE;
              end
            end
          end
          PH_EOT: begin
            if (is_ack) begin
              st_nxt.phase = PH_IDLE;
            end else begin
              st_nxt.try_count = try_inc;
              if (lim_hit) begin
                st_nxt.phase = PH_IDLE;
              end
            end
          end
          default: begin
          end
        endcase
      end
      KIND_ABORT: begin
        if (st.phase != PH_IDLE) begin
          st_nxt.phase    = PH_IDLE;
          st_nxt.can_seen = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // action
  always_comb begin
    action = ACT_NONE;
    case (item.kind)
      KIND_BLOCK: begin
        if (st.method == METH_NONE) begin
          action = ACT_BLOCK_ACKED;
        end
      end
      KIND_BYTE, KIND_TIMEOUT: begin
        case (st.phase)
          PH_START: begin
            if (s_ok) begin
              action = ACT_START_OK;
            end else if (can_pair) begin
              action = ACT_REMOTE_CAN;
            end else if (!can_first && lim_hit) begin
              action = ACT_START_TMO;
            end
          end
          PH_BLOCK: begin
            if (can_pair) begin
              action = ACT_REMOTE_CAN;
            end else if (blk_ack) begin
              action = ACT_BLOCK_ACKED;
            end else if (can_first) begin
              action = ACT_NONE;
            end else begin
              action = lim_hit ? ACT_TOO_MANY : ACT_RESEND_BLK;
            end
          end
          PH_EOT: begin
            if (is_ack) begin
              action = ACT_COMPLETE;
            end else begin
              action = lim_hit ? ACT_NO_ACK : ACT_RESEND_EOT;
            end
          end
          default: begin
          end
        endcase
      end
      KIND_ABORT: begin
        if (st.phase != PH_IDLE) begin
          action = ACT_USER_ABORT;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hdl/xmodem_sender_handshake_unit.sv
// xmodem / ymodem sender handshake controller, top level
// the result of an accepted request is registered in the output register
// throughput: one request per cycle while in_stall is low; state updates as the request is taken
// a result waiting in the output register holds the input only while out_stall is high
// synchronous active-low reset: idle phase, checksum method, counts zero,
// allowed_checks crc or checksum, error_limit ten
module xmodem_sender_handshake_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  xsh_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output xsh_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import xsh_pkg::*;

  cfg_t      cfg_r;
  hs_state_t st_r;
  hs_state_t st_nxt;
  action_t   act;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      accept;

  xsh_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (in_data),
    .st_nxt (st_nxt),
    .action (act)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.allowed_checks <= ALLOWED_CHECKS_RST;
      cfg_r.error_limit    <= ERROR_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ALLOWED_CHECKS: cfg_r.allowed_checks <= cfg_data[1:0];
        CFG_ERROR_LIMIT:    cfg_r.error_limit    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase       <= PH_IDLE;
      st_r.can_seen    <= 1'b0;
      st_r.method      <= METH_SUM;
      st_r.try_count   <= 8'd0;
      st_r.error_total <= 16'd0;
      out_valid_r      <= 1'b0;
    end else begin
      if (accept) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.action       <= act;
      out_data_r.check_method <= st_nxt.method;
      out_data_r.phase_errors <= st_nxt.try_count;
      out_data_r.total_errors <= st_nxt.error_total;
    end
  end

endmodule

FILE: sim/xsh_answer_checker.sv
// answer checker for the xmodem sender handshake unit: watches the request,
// answer and register channels, predicts every answer and compares it field by field
// depends on xsh_pkg for the request, answer and code definitions
module xsh_answer_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  xsh_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  xsh_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output int                 mismatches,
  output int                 pending_answers,
  output int                 answers_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import xsh_pkg::*;

  // shadow copy of the handshake state and registers
  phase_t      hs_phase;
  logic [1:0]  hs_method;
  logic [7:0]  hs_tries;
  logic [15:0] hs_total;
  logic        hs_can;
  logic [1:0]  reg_checks;
  logic [7:0]  reg_limit;

  out_item_t predicted_answers[$];

  initial begin
    mismatches = 0;
    answers_checked = 0;
    pending_answers = 0;
  end

  // one failed try; true once the per-phase limit is reached
  function automatic logic count_failed_try();
    if (hs_tries != 8'hFF) hs_tries = hs_tries + 8'd1;
    return hs_tries >= reg_limit;
  endfunction

  function automatic out_item_t advance_handshake(in_item_t req);
    action_t    act;
    logic       got_byte;
    logic [7:0] b;
    act = ACT_NONE;
    got_byte = (req.kind == KIND_BYTE);
    b = req.line_byte;
    case (req.kind)
      KIND_START: begin
        hs_phase = PH_START;
        hs_tries = 8'd0;
        hs_can = 1'b0;
        if (req.new_transfer) hs_total = 16'd0;
      end
      KIND_BLOCK: begin
        // a block sent while still waiting on one is a resend
        if (hs_phase != PH_BLOCK) hs_tries = 8'd0;
        hs_can = 1'b0;
        if (hs_method == METH_NONE) begin
          hs_phase = PH_IDLE;
          act = ACT_BLOCK_ACKED;
        end else begin
          hs_phase = PH_BLOCK;
        end
      end
      KIND_EOT: begin
        if (hs_phase != PH_EOT) hs_tries = 8'd0;
        hs_can = 1'b0;
        hs_phase = PH_EOT;
      end
      KIND_BYTE, KIND_TIMEOUT: begin
        case (hs_phase)
          PH_START: begin
            if (got_byte && hs_can && b == SYM_CAN) begin
              hs_can = 1'b0;
              hs_phase = PH_IDLE;
              act = ACT_REMOTE_CAN;
            end else if (got_byte && !hs_can && b == SYM_CAN) begin
              hs_can = 1'b1;
            end else if (got_byte && !hs_can && b == SYM_NAK &&
                         (reg_checks == CHK_SUM_ONLY || reg_checks == CHK_EITHER)) begin
              hs_method = METH_SUM;
              hs_phase = PH_IDLE;
              act = ACT_START_OK;
            end else if (got_byte && !hs_can && b == SYM_CRC &&
                         (reg_checks == CHK_CRC_ONLY || reg_checks == CHK_EITHER)) begin
              hs_method = METH_CRC;
              hs_phase = PH_IDLE;
              act = ACT_START_OK;
            end else if (got_byte && !hs_can && b == SYM_GMODE &&
                         reg_checks == CHK_NONE) begin
              hs_method = METH_NONE;
              hs_phase = PH_IDLE;
              act = ACT_START_OK;
            end else begin
              hs_can = 1'b0;
              if (count_failed_try()) begin
                hs_phase = PH_IDLE;
                act = ACT_START_TMO;
              end
            end
          end
          PH_BLOCK: begin
            if (got_byte && hs_can && b == SYM_CAN) begin
              hs_can = 1'b0;
              hs_phase = PH_IDLE;
              act = ACT_REMOTE_CAN;
            end else if (got_byte && !hs_can && b == SYM_CAN) begin
              hs_can = 1'b1;
            end else if (got_byte && !hs_can && b == SYM_ACK) begin
              hs_phase = PH_IDLE;
              act = ACT_BLOCK_ACKED;
            end else begin
              hs_can = 1'b0;
              if (hs_total != 16'hFFFF) hs_total = hs_total + 16'd1;
              if (count_failed_try()) begin
                hs_phase = PH_IDLE;
                act = ACT_TOO_MANY;
              end else begin
                act = ACT_RESEND_BLK;
              end
            end
          end
          PH_EOT: begin
            // cancel has no meaning here; an ack ends the phase, as does reaching the try limit
            if (got_byte && b == SYM_ACK) begin
              hs_phase = PH_IDLE;
              act = ACT_COMPLETE;
            end else if (count_failed_try()) begin
              hs_phase = PH_IDLE;
              act = ACT_NO_ACK;
            end else begin
              act = ACT_RESEND_EOT;
            end
          end
          default: ;
        endcase
      end
      KIND_ABORT: begin
        if (hs_phase != PH_IDLE) begin
          hs_phase = PH_IDLE;
          hs_can = 1'b0;
          act = ACT_USER_ABORT;
        end
      end
      default: ;
    endcase
    return {act, hs_method, hs_tries, hs_total};
  endfunction

  task automatic compare_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      hs_phase = PH_IDLE;
      hs_method = METH_SUM;
      hs_tries = 8'd0;
      hs_total = 16'd0;
      hs_can = 1'b0;
      reg_checks = ALLOWED_CHECKS_RST;
      reg_limit = ERROR_LIMIT_RST;
      predicted_answers.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ALLOWED_CHECKS: reg_checks = cfg_data[1:0];
          CFG_ERROR_LIMIT:    reg_limit = cfg_data;
          default: ;
        endcase
      end
      // the answer leaving now belongs to an earlier request, so retire it first
      if (out_valid && !out_stall) begin
        if (predicted_answers.size() == 0) begin
          $error("answer with no request outstanding: %h", out_data);
          mismatches++;
        end else begin
          want = predicted_answers.pop_front();
          compare_field("action", want.action, out_data.action);
          compare_field("check_method", want.check_method, out_data.check_method);
          compare_field("phase_errors", want.phase_errors, out_data.phase_errors);
          compare_field("total_errors", want.total_errors, out_data.total_errors);
          answers_checked++;
        end
      end
      if (in_valid && !in_stall) predicted_answers.push_back(advance_handshake(in_data));
    end
    pending_answers <= predicted_answers.size();
  end

endmodule

FILE: sim/xmodem_sender_handshake_unit_test.sv
// top of the xmodem sender handshake testbench: clock, reset, request and
// register stimulus, receiver stalls and the verdict
// depends on xsh_pkg, xmodem_sender_handshake_unit and xsh_answer_checker
module xmodem_sender_handshake_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import xsh_pkg::*;

  localparam logic [2:0] KIND_UNUSED_A = 3'd6;
  localparam logic [2:0] KIND_UNUSED_B = 3'd7;
  localparam logic [1:0] CFG_SPARE     = 2'd3;
  localparam int SETTING_ITEMS     = 250;
  localparam int HOLD_CYCLES       = 120;
  localparam int QUIET_LIMIT       = 2000;
  localparam int LATENCY_PAD       = 4;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  int mismatches;
  int pending_answers;
  int answers_checked;
  int requests_sent = 0;
  int settings_written = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_token = 1'b0;
  logic hold_seen = 1'b0;
  logic [1:0] cur_checks = ALLOWED_CHECKS_RST;

  xmodem_sender_handshake_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  xsh_answer_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending_answers (pending_answers),
    .answers_checked (answers_checked)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // receiver: random stalls, or one long hold-off each time the token flips
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_request(logic [2:0] req_kind, logic [7:0] req_byte, logic req_fresh);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {req_kind, req_byte, req_fresh};
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  task automatic configure(logic [1:0] checks, logic [7:0] limit);
    // an index with no register behind it must change nothing
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SPARE;
    cfg_data <= 8'($urandom);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_ALLOWED_CHECKS;
    cfg_data <= {6'($urandom), checks};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_ERROR_LIMIT;
    cfg_data <= limit;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_checks = checks;
    settings_written++;
  endtask

  task automatic wait_answers();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_answers != 0);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  task automatic send_line_noise();
    case ($urandom_range(3))
      0: send_request(KIND_TIMEOUT, 8'($urandom), 1'($urandom));
      1: send_request(KIND_BYTE, SYM_CAN, 1'($urandom));
      2: send_request(KIND_BYTE, SYM_NAK, 1'($urandom));
      default: send_request(KIND_BYTE, 8'($urandom), 1'($urandom));
    endcase
  endtask

  // one transfer as a sender would see it, with line trouble mixed in
  task automatic run_session();
    logic [7:0] opener;
    int         n_blocks;
    send_request(KIND_START, 8'($urandom), $urandom_range(3) == 0);
    repeat ($urandom_range(2)) send_line_noise();
    case ($urandom_range(9))
      0: opener = SYM_NAK;
      1: opener = SYM_CRC;
      2: opener = SYM_GMODE;
      default: begin
        case (cur_checks)
          CHK_SUM_ONLY: opener = SYM_NAK;
          CHK_CRC_ONLY: opener = SYM_CRC;
          CHK_NONE:     opener = SYM_GMODE;
          default:      opener = $urandom_range(1) ? SYM_NAK : SYM_CRC;
        endcase
      end
    endcase
    send_request(KIND_BYTE, opener, 1'($urandom));
    n_blocks = $urandom_range(1, 6);
    repeat (n_blocks) begin
      send_request(KIND_BLOCK, 8'($urandom), 1'($urandom));
      if ($urandom_range(99) < 25) begin
        repeat ($urandom_range(1, 3)) begin
          send_line_noise();
          send_request(KIND_BLOCK, 8'($urandom), 1'($urandom));
        end
      end
      case ($urandom_range(29))
        0: begin
          send_request(KIND_BYTE, SYM_CAN, 1'($urandom));
          send_request(KIND_BYTE, SYM_CAN, 1'($urandom));
        end
        1: send_request(KIND_ABORT, 8'($urandom), 1'($urandom));
        default: send_request(KIND_BYTE, SYM_ACK, 1'($urandom));
      endcase
    end
    send_request(KIND_EOT, 8'($urandom), 1'($urandom));
    repeat ($urandom_range(2)) begin
      send_line_noise();
      send_request(KIND_EOT, 8'($urandom), 1'($urandom));
    end
    send_request(KIND_BYTE, SYM_ACK, 1'($urandom));
  endtask

  task automatic run_random(int budget);
    int first;
    first = requests_sent;
    while (requests_sent - first < budget) begin
      if ($urandom_range(9) == 0)
        send_request(3'($urandom_range(7)), 8'($urandom), 1'($urandom));
      else
        run_session();
    end
  endtask

  task automatic run_setting(logic [1:0] checks, logic [7:0] limit,
                             int snd_pct, int rcv_pct, bit long_hold);
    configure(checks, limit);
    sender_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    if (long_hold) begin
      // keep offering while the receiver holds off so the input backs up
      hold_token <= ~hold_token;
      run_random(12);
    end
    run_random(SETTING_ITEMS);
    wait_answers();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ALLOWED_CHECKS;
    cfg_data = 8'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(CHK_EITHER, 8'd10);
    // nothing is waiting, so these are answered with no action
    send_request(KIND_ABORT, 8'h00, 1'b1);
    send_request(KIND_BYTE, 8'hFF, 1'b0);
    send_request(KIND_TIMEOUT, SYM_ACK, 1'b0);
    send_request(KIND_UNUSED_A, 8'hFF, 1'b1);
    send_request(KIND_UNUSED_B, SYM_CAN, 1'b0);
    send_request(KIND_START, 8'h00, 1'b1);
    send_request(KIND_BYTE, SYM_CAN, 1'b0);
    send_request(KIND_BYTE, 8'h00, 1'b0);       // counts as a failed try after a lone cancel
    send_request(KIND_BYTE, SYM_CAN, 1'b0);
    send_request(KIND_BYTE, SYM_CAN, 1'b0);     // two in a row cancel
    send_request(KIND_START, 8'hFF, 1'b0);
    send_request(KIND_BYTE, SYM_GMODE, 1'b0);   // streaming not allowed here
    send_request(KIND_TIMEOUT, 8'h00, 1'b1);
    send_request(KIND_BYTE, SYM_CRC, 1'b0);
    send_request(KIND_BLOCK, 8'h00, 1'b0);
    send_request(KIND_BYTE, SYM_NAK, 1'b0);
    send_request(KIND_BLOCK, 8'hFF, 1'b1);      // resend keeps the try count
    send_request(KIND_TIMEOUT, 8'hFF, 1'b0);
    send_request(KIND_BLOCK, 8'h00, 1'b0);
    send_request(KIND_BYTE, SYM_CAN, 1'b0);
    send_request(KIND_BYTE, SYM_ACK, 1'b0);     // ack behind a lone cancel is a failure
    send_request(KIND_BLOCK, 8'h00, 1'b0);
    send_request(KIND_ABORT, 8'hFF, 1'b0);
    send_request(KIND_EOT, 8'h00, 1'b0);
    send_request(KIND_BYTE, SYM_CAN, 1'b0);     // plain byte while waiting on eot
    send_request(KIND_EOT, 8'h00, 1'b0);
    send_request(KIND_BYTE, SYM_ACK, 1'b0);
    wait_answers();

    run_setting(CHK_SUM_ONLY, 8'd1, 33, 45, 1'b1);
    run_setting(CHK_CRC_ONLY, 8'd255, 33, 45, 1'b0);
    run_setting(CHK_NONE, 8'd3, 45, 33, 1'b1);
    run_setting(CHK_EITHER, 8'd0, 45, 33, 1'b0);
    run_setting(CHK_NONE, 8'd20, 0, 0, 1'b0);
    run_setting(CHK_EITHER, 8'($urandom_range(1, 255)), 0, 0, 1'b1);

    repeat (10) @(posedge clk);
    $display("run covered %0d requests and %0d checked answers over %0d register settings",
             requests_sent, answers_checked, settings_written);
    $display("with idle and stall mixes, long receiver hold-offs and drained pauses");
    if (mismatches == 0 && pending_answers == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: files.f
hdl/xsh_pkg.sv
hdl/xsh_step.sv
hdl/xmodem_sender_handshake_unit.sv
sim/xsh_answer_checker.sv
sim/xmodem_sender_handshake_unit_test.sv
